[src/acsp_pkg.sv]
// Shared types and constants of the escape sequence parser.
package acsp_pkg;

    localparam int MAX_PARAMETERS = 16;
    localparam int PIDX_W = $clog2(MAX_PARAMETERS);
    localparam int PCNT_W = $clog2(MAX_PARAMETERS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W = $clog2(QUEUE_DEPTH);

    localparam logic [4:0] CMD_PUT_CHAR     = 5'd0;
    localparam logic [4:0] CMD_SAVE         = 5'd1;
    localparam logic [4:0] CMD_RESTORE      = 5'd2;
    localparam logic [4:0] CMD_COLORS       = 5'd3;
    localparam logic [4:0] CMD_MOVE         = 5'd4;
    localparam logic [4:0] CMD_UP           = 5'd5;
    localparam logic [4:0] CMD_DOWN         = 5'd6;
    localparam logic [4:0] CMD_FORWARD      = 5'd7;
    localparam logic [4:0] CMD_BACK         = 5'd8;
    localparam logic [4:0] CMD_ERASE_DISPLAY = 5'd9;
    localparam logic [4:0] CMD_CLEAR_LINE   = 5'd10;
    localparam logic [4:0] CMD_SCROLL_REGION = 5'd11;
    localparam logic [4:0] CMD_SHOW_CURSOR  = 5'd12;
    localparam logic [4:0] CMD_INS_CHARS    = 5'd13;
    localparam logic [4:0] CMD_DEL_CHARS    = 5'd14;
    localparam logic [4:0] CMD_INS_LINES    = 5'd15;
    localparam logic [4:0] CMD_DEL_LINES    = 5'd16;
    localparam logic [4:0] CMD_SCROLL_UP    = 5'd17;
    localparam logic [4:0] CMD_SCROLL_DOWN  = 5'd18;
    localparam logic [4:0] CMD_ATTR_REPLY   = 5'd19;
    localparam logic [4:0] CMD_STATUS_REPLY = 5'd20;
    localparam logic [4:0] CMD_POS_REPORT   = 5'd21;

    localparam logic [0:0] REG_DEFAULT_FG = 1'd0;
    localparam logic [0:0] REG_DEFAULT_BG = 1'd1;

    // pair: save followed by erase display 2
    typedef struct packed {
        logic [4:0]  cmd;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic        pair;
    } job_t;

endpackage

[src/ansi_escape_sequence_parser_unit.sv]
// Top level of the ANSI escape sequence parser.
// Input channel: byte_in with in_valid/in_stall; a beat moves when valid is
// high and stall is low. Output channel: command, arg_first, arg_second and
// last_of_run with out_valid/out_stall, one beat per display command; the
// last beat caused by an input byte has last_of_run set. A byte causes zero,
// one or two beats.
// One byte per cycle is taken while the queue has room and the parser is
// not walking; a result beat passes through the job queue and then the
// output register. After an SGR final byte the input stalls while the
// parser walks the parameter store and until it has pushed the colors job.
// Between parser and output sits a four-entry job queue; when it fills
// because the receiver stalls, in_stall rises and holds until room frees.
// Reset empties the queue and output, returns to normal mode and loads the
// default colors 7 and 0. Registers are written with cfg_write, cfg_index
// (0 foreground, 1 background) and cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce.
module ansi_escape_sequence_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  command,
    output logic [15:0] arg_first,
    output logic [15:0] arg_second,
    output logic        last_of_run,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    import acsp_pkg::*;

    logic q_full, push, pop, not_empty;
    job_t push_job, head;

    acsp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .byte_in(byte_in), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .q_full(q_full), .push(push), .push_job(push_job)
    );

    acsp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .full(q_full),
        .pop(pop), .not_empty(not_empty), .head(head)
    );

    acsp_back u_back (
        .clk(clk), .rst_n(rst_n), .not_empty(not_empty), .head(head), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .command(command),
        .arg_first(arg_first), .arg_second(arg_second), .last_of_run(last_of_run)
    );

endmodule

[src/acsp_front.sv]
// Front end: byte parser, parameter store, SGR walk and command classification.
module acsp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       byte_in,
    input  logic             cfg_write,
    input  logic [0:0]       cfg_index,
    input  logic [3:0]       cfg_data,
    input  logic             q_full,
    output logic             push,
    output acsp_pkg::job_t   push_job
);
    import acsp_pkg::*;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_ESCAPE = 5'b00010,
        MODE_CSI    = 5'b00100,
        MODE_OSC    = 5'b01000,
        MODE_WALK   = 5'b10000
    } mode_t;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_BEL = 8'h07;

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic        digit_reg, digit_next;
    logic        priv_reg, priv_next;
    logic [PCNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0] store_reg [MAX_PARAMETERS];
    logic [3:0]  fg_reg, fg_next, bg_reg, bg_next;
    logic [3:0]  def_fg_reg, def_bg_reg;
    logic [PCNT_W-1:0] walk_idx_reg, walk_idx_next, walk_len_reg, walk_len_next;

    logic        accept;
    logic        store_en;
    logic [19:0] acc_mul;
    logic        room;
    logic [PCNT_W-1:0] cnt_eff;
    logic [15:0] p0, p1, wp;
    logic        has;

    assign in_stall = (mode_reg == MODE_WALK) || q_full;
    assign accept   = in_valid && !in_stall;
    assign room     = cnt_reg < PCNT_W'(MAX_PARAMETERS);
    assign acc_mul  = {4'd0, acc_reg} * 20'd10 + {16'd0, byte_in[3:0]};
    assign cnt_eff  = cnt_reg + PCNT_W'(digit_reg && room);
    assign has      = cnt_eff != '0;
    assign p0       = (cnt_reg == '0) ? acc_reg : store_reg[0];
    assign p1       = (cnt_reg == PCNT_W'(1)) ? acc_reg : store_reg[1];
    assign wp       = store_reg[walk_idx_reg[PIDX_W-1:0]];

    function automatic job_t mk(input logic [4:0] c, input logic [15:0] a,
                                input logic [15:0] b);
        job_t j;
        j.cmd = c;
        j.arg_a = a;
        j.arg_b = b;
        j.pair = 1'b0;
        return j;
    endfunction

    always_comb
    begin
        logic [15:0] n1;
        logic        alt;
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        digit_next    = digit_reg;
        priv_next     = priv_reg;
        cnt_next      = cnt_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        walk_idx_next = walk_idx_reg;
        walk_len_next = walk_len_reg;
        store_en      = 1'b0;
        push          = 1'b0;
        push_job      = mk(CMD_PUT_CHAR, 16'd0, 16'd0);
        n1  = has ? p0 : 16'd1;
        alt = (p0 == 16'd47) || (p0 == 16'd1047) || (p0 == 16'd1049);
        case (mode_reg)
            MODE_WALK:
            begin
                if (walk_idx_reg < walk_len_reg)
                begin
                    if (wp == 16'd0)
                    begin
                        fg_next = def_fg_reg;
                        bg_next = def_bg_reg;
                    end
                    else if (wp >= 16'd30 && wp <= 16'd37)
                        fg_next = 4'(wp - 16'd30);
                    else if (wp >= 16'd40 && wp <= 16'd47)
                        bg_next = 4'(wp - 16'd40);
                    else if (wp >= 16'd90 && wp <= 16'd97)
                        fg_next = 4'(wp - 16'd82);
                    else if (wp >= 16'd100 && wp <= 16'd107)
                        bg_next = 4'(wp - 16'd92);
                    walk_idx_next = walk_idx_reg + PCNT_W'(1);
                end
                else if (!q_full)
                begin
                    push      = 1'b1;
                    push_job  = mk(CMD_COLORS, {12'd0, fg_reg}, {12'd0, bg_reg});
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_NORMAL:
            begin
                if (accept)
                begin
                    if (byte_in == CH_ESC)
                        mode_next = MODE_ESCAPE;
                    else
                    begin
                        push     = 1'b1;
                        push_job = mk(CMD_PUT_CHAR, {8'd0, byte_in}, 16'd0);
                    end
                end
            end
            MODE_ESCAPE:
            begin
                if (accept)
                begin
                    if (byte_in == "[")
                        mode_next = MODE_CSI;
                    else if (byte_in == "]")
                        mode_next = MODE_OSC;
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        if (byte_in == "7")
                        begin
                            push     = 1'b1;
                            push_job = mk(CMD_SAVE, 16'd0, 16'd0);
                        end
                        else if (byte_in == "8")
                        begin
                            push     = 1'b1;
                            push_job = mk(CMD_RESTORE, 16'd0, 16'd0);
                        end
                    end
                end
            end
            MODE_OSC:
            begin
                if (accept && (byte_in == CH_BEL || byte_in == CH_ESC))
                    mode_next = MODE_NORMAL;
            end
            MODE_CSI:
            begin
                if (accept)
                begin
                    if (byte_in >= "0" && byte_in <= "9")
                    begin
                        acc_next   = (acc_mul > 20'hFFFF) ? 16'hFFFF : acc_mul[15:0];
                        digit_next = 1'b1;
                    end
                    else if (byte_in == ";")
                    begin
                        store_en   = room;
                        cnt_next   = cnt_reg + PCNT_W'(room);
                        acc_next   = 16'd0;
                        digit_next = 1'b0;
                    end
                    else if (byte_in == "?")
                        priv_next = 1'b1;
                    else
                    begin
                        store_en   = digit_reg && room;
                        cnt_next   = '0;
                        acc_next   = 16'd0;
                        digit_next = 1'b0;
                        priv_next  = 1'b0;
                        mode_next  = MODE_NORMAL;
                        push       = 1'b1;
                        case (byte_in)
                            "m":
                            begin
                                push          = 1'b0;
                                mode_next     = MODE_WALK;
                                fg_next       = def_fg_reg;
                                bg_next       = def_bg_reg;
                                walk_idx_next = '0;
                                walk_len_next = cnt_eff;
                            end
                            "H", "f": push_job = mk(CMD_MOVE, n1,
                                (cnt_eff > PCNT_W'(1)) ? p1 : 16'd1);
                            "A": push_job = mk(CMD_UP, n1, 16'd0);
                            "B": push_job = mk(CMD_DOWN, n1, 16'd0);
                            "C": push_job = mk(CMD_FORWARD, n1, 16'd0);
                            "D": push_job = mk(CMD_BACK, n1, 16'd0);
                            "J": push_job = mk(CMD_ERASE_DISPLAY, has ? p0 : 16'd0, 16'd0);
                            "K": push_job = mk(CMD_CLEAR_LINE, has ? p0 : 16'd0, 16'd0);
                            "r": push_job = mk(CMD_SCROLL_REGION, n1,
                                (cnt_eff > PCNT_W'(1)) ? p1 : 16'd0);
                            "h":
                            begin
                                push = priv_reg && has && (p0 == 16'd25 || alt);
                                if (p0 == 16'd25)
                                    push_job = mk(CMD_SHOW_CURSOR, 16'd1, 16'd0);
                                else
                                begin
                                    push_job      = mk(CMD_SAVE, 16'd0, 16'd0);
                                    push_job.pair = 1'b1;
                                end
                            end
                            "l":
                            begin
                                push = priv_reg && has && (p0 == 16'd25 || alt);
                                if (p0 == 16'd25)
                                    push_job = mk(CMD_SHOW_CURSOR, 16'd0, 16'd0);
                                else
                                    push_job = mk(CMD_RESTORE, 16'd0, 16'd0);
                            end
                            "I": push_job = mk(CMD_INS_CHARS, n1, 16'd0);
                            "P": push_job = mk(CMD_DEL_CHARS, n1, 16'd0);
                            "L": push_job = mk(CMD_INS_LINES, n1, 16'd0);
                            "M": push_job = mk(CMD_DEL_LINES, n1, 16'd0);
                            "S": push_job = mk(CMD_SCROLL_UP, n1, 16'd0);
                            "T": push_job = mk(CMD_SCROLL_DOWN, n1, 16'd0);
                            "c":
                            begin
                                push     = !has || p0 == 16'd0;
                                push_job = mk(CMD_ATTR_REPLY, 16'd0, 16'd0);
                            end
                            "n":
                            begin
                                push = !has || p0 == 16'd5 || p0 == 16'd6;
                                push_job = mk((has && p0 == 16'd6) ? CMD_POS_REPORT
                                              : CMD_STATUS_REPLY, 16'd0, 16'd0);
                            end
                            "s": push_job = mk(CMD_SAVE, 16'd0, 16'd0);
                            "u": push_job = mk(CMD_RESTORE, 16'd0, 16'd0);
                            default: push = 1'b0;
                        endcase
                    end
                end
            end
            default: mode_next = MODE_NORMAL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NORMAL;
            acc_reg      <= 16'd0;
            digit_reg    <= 1'b0;
            priv_reg     <= 1'b0;
            cnt_reg      <= '0;
            walk_idx_reg <= '0;
            walk_len_reg <= '0;
            def_fg_reg   <= 4'd7;
            def_bg_reg   <= 4'd0;
        end
        else
        begin
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            digit_reg    <= digit_next;
            priv_reg     <= priv_next;
            cnt_reg      <= cnt_next;
            walk_idx_reg <= walk_idx_next;
            walk_len_reg <= walk_len_next;
            if (cfg_write && cfg_index == REG_DEFAULT_FG)
                def_fg_reg <= cfg_data;
            if (cfg_write && cfg_index == REG_DEFAULT_BG)
                def_bg_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        fg_reg <= fg_next;
        bg_reg <= bg_next;
        if (store_en)
            store_reg[cnt_reg[PIDX_W-1:0]] <= acc_reg;
    end

endmodule

[src/acsp_queue.sv]
// Short job queue between parser front and output back end.
module acsp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  acsp_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output acsp_pkg::job_t head
);
    import acsp_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign full      = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = slot_reg[rd_reg];
    assign do_pop    = pop && not_empty;
    assign rd_next   = rd_reg + QIDX_W'(do_pop);
    assign wr_next   = wr_reg + QIDX_W'(push);
    assign cnt_next  = cnt_reg + QCNT_W'(push) - QCNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

[src/acsp_back.sv]
// Back end: expands jobs into result beats and holds the output register.
module acsp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           not_empty,
    input  acsp_pkg::job_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [4:0]     command,
    output logic [15:0]    arg_first,
    output logic [15:0]    arg_second,
    output logic           last_of_run
);
    import acsp_pkg::*;

    logic        valid_reg, second_reg;
    logic [4:0]  cmd_reg;
    logic [15:0] a_reg, b_reg;
    logic        last_reg;
    logic        load;

    assign load = !valid_reg || !out_stall;
    assign pop  = load && !second_reg && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (load)
        begin
            if (second_reg)
            begin
                valid_reg  <= 1'b1;
                second_reg <= 1'b0;
            end
            else
            begin
                valid_reg  <= not_empty;
                second_reg <= not_empty && head.pair;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (second_reg)
            begin
                cmd_reg  <= CMD_ERASE_DISPLAY;
                a_reg    <= 16'd2;
                b_reg    <= 16'd0;
                last_reg <= 1'b1;
            end
            else
            begin
                cmd_reg  <= head.cmd;
                a_reg    <= head.arg_a;
                b_reg    <= head.arg_b;
                last_reg <= !head.pair;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign command     = cmd_reg;
    assign arg_first   = a_reg;
    assign arg_second  = b_reg;
    assign last_of_run = last_reg;

endmodule

[src/acsp_checker.sv]
// Port-level assertions for the parser, bound to the top level.
module acsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  command,
    input logic [15:0] arg_first,
    input logic [15:0] arg_second,
    input logic        last_of_run
);
    import acsp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command) && $stable(arg_first))
        else $error("stalled beat changed");

    a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> command == CMD_SAVE)
        else $error("non-final beat is not save");

    a_pair_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=>
        out_valid && last_of_run && command == CMD_ERASE_DISPLAY && arg_first == 16'd2)
        else $error("save not followed by erase display 2");

    a_second_arg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && arg_second != 16'd0 |->
        command == CMD_COLORS || command == CMD_MOVE || command == CMD_SCROLL_REGION)
        else $error("unexpected second argument");

endmodule

bind ansi_escape_sequence_parser_unit acsp_checker u_acsp_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .command(command), .arg_first(arg_first), .arg_second(arg_second),
    .last_of_run(last_of_run)
);
